// ----- rtl/core/first_fit_page_run_allocator_assert.svh -----
// assertion macros for the first-fit page run allocator checker
`ifndef FIRST_FIT_PAGE_RUN_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_PAGE_RUN_ALLOCATOR_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define FFPRA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("first_fit_page_run_allocator: same-cycle check failed");

// next-cycle implication
`define FFPRA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("first_fit_page_run_allocator: next-cycle check failed");

`endif

// ----- rtl/core/ffpra_pkg.sv -----
// shared widths, codes and controller/datapath interface types
package ffpra_pkg;

    localparam int ADDR_W    = 48;
    localparam int SIZE_W    = 32;
    localparam int SHIFT_W   = 5;
    localparam int CNT_W     = 11;
    localparam int PAGE_W    = 10;
    localparam int ST_W      = 2;
    localparam int RUN_W     = 11;
    localparam int POS_W     = 12;
    localparam int NEED_W    = SIZE_W + 1;
    localparam int CFG_IDX_W = 2;

    localparam int NUM_PAGES_DEF = 1024;

    localparam logic [SHIFT_W-1:0] MAX_SHIFT     = 5'd20;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET   = 5'd12;
    localparam logic [CNT_W-1:0]   COUNT_RESET   = 11'd1024;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd2;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_NOROOM = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD    = 2'd2;

    // request kinds
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic load;      // latch request fields
        logic clear;     // clear one table entry
        logic achk;      // size check, need calc, first read
        logic walk;      // one first-fit step
        logic afin;      // commit or reject the allocation
        logic fchk;      // free address check and table read
        logic free_rd;   // release the entry that was read
        logic out_load;  // move result into the output register
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic achk_go;
        logic walk_done;
        logic fchk_go;
        logic out_free;
    } t_stat;

endpackage

// ----- rtl/core/first_fit_page_run_allocator.sv -----
// First-fit page run allocator. One request is handled at a time. An allocate
// checks the size, walks the run table first-fit one entry at a time (free
// pages one by one, allocated runs skipped in one step) and then commits or
// rejects; the walk is bound by the single read port of the run table. A free
// checks its address, then reads and releases its entry; an allocate of size
// zero or a null or bad free goes straight to the result. The result sits in
// an output register, and the next request is taken once the result has been
// moved there. After reset the run table is cleared one entry per cycle, with
// the request input stalled; configuration writes are taken at any time (ready
// is tied high) and must only be made while no request is in flight.
module first_fit_page_run_allocator
    import ffpra_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_func,
    input  logic [SIZE_W-1:0]    i_request_size,
    input  logic [ADDR_W-1:0]    i_free_address,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [ST_W-1:0]      o_status,
    output logic [ADDR_W-1:0]    o_granted_address,
    output logic [PAGE_W-1:0]    o_granted_page,
    output logic [CNT_W-1:0]     o_reserved_pages
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    ffpra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    ffpra_dp #(
        .NUM_PAGES (NUM_PAGES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_request_size    (i_request_size),
        .i_free_address    (i_free_address),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_status          (o_status),
        .o_granted_address (o_granted_address),
        .o_granted_page    (o_granted_page),
        .o_reserved_pages  (o_reserved_pages)
    );

endmodule

// ----- rtl/core/ffpra_ctrl.sv -----
// sequencing state machine of the page run allocator
module ffpra_ctrl
    import ffpra_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_func,
    input  t_stat i_stat,
    output logic  o_in_stall,
    output t_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_ACHK  = 8'b0000_0100,
        S_WALK  = 8'b0000_1000,
        S_AFIN  = 8'b0001_0000,
        S_FCHK  = 8'b0010_0000,
        S_FREAD = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_func == FUNC_FREE) ? S_FCHK : S_ACHK;
                end
            end
            S_ACHK: begin
                o_cmd.achk = 1'b1;
                n_state    = i_stat.achk_go ? S_WALK : S_DONE;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.walk_done) begin
                    n_state = S_AFIN;
                end
            end
            S_AFIN: begin
                o_cmd.afin = 1'b1;
                n_state    = S_DONE;
            end
            S_FCHK: begin
                o_cmd.fchk = 1'b1;
                n_state    = i_stat.fchk_go ? S_FREAD : S_DONE;
            end
            S_FREAD: begin
                o_cmd.free_rd = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// ----- rtl/core/ffpra_dp.sv -----
// run table, config registers, walk counters and result registers
module ffpra_dp
    import ffpra_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    input  logic [SIZE_W-1:0]    i_request_size,
    input  logic [ADDR_W-1:0]    i_free_address,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic [ST_W-1:0]      o_status,
    output logic [ADDR_W-1:0]    o_granted_address,
    output logic [PAGE_W-1:0]    o_granted_page,
    output logic [CNT_W-1:0]     o_reserved_pages
);

    localparam int IW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int CNT_MAX = (2 ** CNT_W) - 1;
    localparam logic [CNT_W-1:0] NP_CLIP =
        CNT_W'((NUM_PAGES > CNT_MAX) ? CNT_MAX : NUM_PAGES);

    function automatic logic [IW-1:0] pos_to_idx(input logic [POS_W-1:0] p);
        logic [IW+POS_W-1:0] ext;
        ext = {{IW{1'b0}}, p};
        return ext[IW-1:0];
    endfunction

    // configuration
    logic [ADDR_W-1:0]  r_base;
    logic [SHIFT_W-1:0] r_shift;
    logic [CNT_W-1:0]   r_count;
    logic [SHIFT_W-1:0] eff_shift;
    logic [CNT_W-1:0]   eff_count;

    // control-side registers
    logic [CNT_W-1:0]   r_resv;
    logic [IW-1:0]      r_clr;
    logic               r_out_valid;

    // payload registers
    logic [SIZE_W-1:0]  r_size;
    logic [ADDR_W-1:0]  r_addr;
    logic [NEED_W-1:0]  r_need;
    logic [POS_W-1:0]   r_pos;
    logic [RUN_W-1:0]   r_run;
    logic [IW-1:0]      r_idx;
    logic [ST_W-1:0]    r_res_status;
    logic [ADDR_W-1:0]  r_res_addr;
    logic [PAGE_W-1:0]  r_res_page;

    // run table
    logic [RUN_W-1:0]   r_mem [NUM_PAGES];
    logic [RUN_W-1:0]   r_q;
    logic [IW-1:0]      rd_addr;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic [RUN_W-1:0]   wr_data;

    // comb helpers
    logic               size_zero;
    logic [NEED_W-1:0]  need;
    logic               q_nz;
    logic [RUN_W-1:0]   run_n;
    logic [POS_W-1:0]   pos_n;
    logic               alloc_ok;
    logic [POS_W-1:0]   start;
    logic [ADDR_W-1:0]  grant_addr;
    logic               addr_null;
    logic               addr_below;
    logic [ADDR_W-1:0]  diff;
    logic [ADDR_W-1:0]  idx_w;
    logic               addr_bad;

    assign eff_shift = (r_shift > MAX_SHIFT) ? MAX_SHIFT : r_shift;
    assign eff_count = (r_count > NP_CLIP) ? NP_CLIP : r_count;

    // allocate: pages needed, rounded up
    assign size_zero = (r_size == '0);
    assign need      = NEED_W'((r_size - SIZE_W'(1)) >> eff_shift) + NEED_W'(1);

    // first-fit step on the entry read last cycle at r_pos
    assign q_nz  = (r_q != '0);
    assign run_n = q_nz ? '0 : r_run + RUN_W'(1);
    assign pos_n = q_nz ? r_pos + POS_W'(r_q) : r_pos + POS_W'(1);

    assign alloc_ok   = (NEED_W'(r_run) == r_need);
    assign start      = r_pos - POS_W'(r_run);
    assign grant_addr = r_base + (ADDR_W'(start) << eff_shift);

    // free: address to page index
    assign addr_null  = (r_addr == '0);
    assign addr_below = (r_addr < r_base);
    assign diff       = r_addr - r_base;
    assign idx_w      = diff >> eff_shift;
    assign addr_bad   = addr_below || (idx_w >= ADDR_W'(eff_count));

    always_comb begin
        o_stat.clr_last  = (r_clr == IW'(NUM_PAGES - 1));
        o_stat.achk_go   = !size_zero && (eff_count != '0);
        o_stat.walk_done = (NEED_W'(run_n) == r_need) || (pos_n >= POS_W'(eff_count));
        o_stat.fchk_go   = !addr_null && !addr_bad;
        o_stat.out_free  = !r_out_valid || !i_out_stall;
    end

    always_comb begin
        rd_addr = r_idx;
        if (i_cmd.achk) begin
            rd_addr = '0;
        end else if (i_cmd.walk) begin
            rd_addr = pos_to_idx(pos_n);
        end else if (i_cmd.fchk) begin
            rd_addr = idx_w[IW-1:0];
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_clr;
        wr_data = '0;
        if (i_cmd.clear) begin
            wr_en = 1'b1;
        end else if (i_cmd.afin && alloc_ok) begin
            wr_en   = 1'b1;
            wr_addr = pos_to_idx(start);
            wr_data = r_run;
        end else if (i_cmd.free_rd) begin
            wr_en   = 1'b1;
            wr_addr = r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_q <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_shift     <= SHIFT_RESET;
            r_count     <= COUNT_RESET;
            r_resv      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_BASE:  r_base  <= i_cfg_data;
                    REG_SHIFT: r_shift <= i_cfg_data[SHIFT_W-1:0];
                    REG_COUNT: r_count <= i_cfg_data[CNT_W-1:0];
                    default:   ;
                endcase
            end
            if (i_cmd.clear) begin
                r_clr <= r_clr + IW'(1);
            end
            if (i_cmd.afin && alloc_ok) begin
                r_resv <= r_resv + CNT_W'(r_run);
            end else if (i_cmd.free_rd) begin
                r_resv <= r_resv - CNT_W'(r_q);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_size <= i_request_size;
            r_addr <= i_free_address;
        end
        if (i_cmd.achk) begin
            r_need       <= need;
            r_pos        <= '0;
            r_run        <= '0;
            r_res_status <= size_zero ? ST_BAD : ST_NOROOM;
            r_res_addr   <= '0;
            r_res_page   <= '0;
        end
        if (i_cmd.walk) begin
            r_pos <= pos_n;
            r_run <= run_n;
        end
        if (i_cmd.afin) begin
            r_res_status <= alloc_ok ? ST_OK : ST_NOROOM;
            r_res_addr   <= alloc_ok ? grant_addr : '0;
            r_res_page   <= alloc_ok ? start[PAGE_W-1:0] : '0;
        end
        if (i_cmd.fchk) begin
            r_idx        <= idx_w[IW-1:0];
            r_res_status <= addr_null ? ST_OK : ST_BAD;
            r_res_addr   <= '0;
            r_res_page   <= '0;
        end
        if (i_cmd.free_rd) begin
            r_res_status <= ST_OK;
        end
        if (i_cmd.out_load) begin
            o_status          <= r_res_status;
            o_granted_address <= r_res_addr;
            o_granted_page    <= r_res_page;
            o_reserved_pages  <= r_resv;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/core/ffpra_chk.sv -----
// port-level checker for the page run allocator and its bind
`include "first_fit_page_run_allocator_assert.svh"

module ffpra_chk
    import ffpra_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 o_in_stall,
    input  logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  logic [ST_W-1:0]      o_status,
    input  logic [ADDR_W-1:0]    o_granted_address,
    input  logic [PAGE_W-1:0]    o_granted_page,
    input  logic [CNT_W-1:0]     o_reserved_pages
);

    logic [ST_W+ADDR_W+PAGE_W+CNT_W-1:0] out_word;
    logic                                out_failed;
    logic                                grant_zero;

    assign out_word   = {o_status, o_granted_address, o_granted_page, o_reserved_pages};
    assign out_failed = o_out_valid && (o_status != ST_OK);
    assign grant_zero = (o_granted_address == '0) && (o_granted_page == '0);

    // a stalled result holds
    `FFPRA_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(out_word))

    // one transaction at a time: the block is busy right after taking one
    `FFPRA_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)

    // a fresh result is only produced while a request is in flight
    `FFPRA_ASSERT_NOW(a_result_from_work, $rose(o_out_valid), $past(o_in_stall))

    // failed results carry no grant
    `FFPRA_ASSERT_NOW(a_no_grant_on_fail, out_failed, grant_zero)

endmodule

bind first_fit_page_run_allocator ffpra_chk u_ffpra_chk (.*);
